// ----- rtl/cptraj_pkg.sv -----
// Shared constants and register index codes for the cubic trajectory block.
package cptraj_pkg;

   // Fraction bits of the normalized time s and of the blend h.
   localparam int FRAC_BITS = 24;
   // Quotient bits: one integer bit (s may reach exactly one) plus the fraction.
   localparam int Q_WIDTH   = FRAC_BITS + 1;
   // s * s.
   localparam int SQ_WIDTH  = 2 * Q_WIDTH;
   // Rounded s^2 in Q2.24 (up to one, plus headroom).
   localparam int S2_WIDTH  = SQ_WIDTH - FRAC_BITS;
   // 3 - 2s in Q3.24.
   localparam int K_WIDTH   = Q_WIDTH + 2;
   // s^2 * (3 - 2s).
   localparam int PROD_WIDTH = S2_WIDTH + K_WIDTH;
   // Rounded product before the clamp.
   localparam int HR_WIDTH  = PROD_WIDTH - FRAC_BITS;

   // Width of the register index on the configuration channel.
   localparam int CSR_INDEX_WIDTH = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INITIAL_POSITION = 8'd0,
      CSR_GOAL_POSITION    = 8'd1,
      CSR_MOVE_DURATION    = 8'd2,
      CSR_START_TIME       = 8'd3
   } csr_index_type;

endpackage

// ----- rtl/cubic_point_to_point_trajectory.sv -----
// Rest-to-rest cubic trajectory for one axis: a time stream in, a position stream out.
//
// Each req item carries the present time in ticks; each rsp item is the commanded
// position (signed Q16.16 at the default width). Before start_time the block returns
// initial_position, after start_time + move_duration it returns goal_position, and in
// between init + (goal - init) * (3s^2 - 2s^3) with s = elapsed / duration in Q1.24,
// rounded to nearest. A move_duration of zero counts as one tick. The block is a
// 32-stage pipeline followed by the output register: one item may enter every cycle while
// req_tready is high. The depth is set by the restoring fraction divider, which settles one
// quotient bit per stage over 25 stages; the polynomial and the final scaling take six more
// stages of one multiply or one add each. A skid register behind the output keeps the input
// open for one more item while a result waits; once both are full, req_tready drops until
// rsp_tready returns. The four registers are written through the csr channel (index 0
// initial_position, 1 goal_position, 2 move_duration, 3 start_time; other indexes are
// ignored), and must only change while no item is in flight.
module cubic_point_to_point_trajectory #(
   parameter int TIME_WIDTH = 32,
   parameter int POS_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,

   // time stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((TIME_WIDTH+7)/8)*8-1:0]      req_tdata,  // current_time

   // position stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((POS_WIDTH+7)/8)*8-1:0]       rsp_tdata,  // position

   // register writes
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [cptraj_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [((TIME_WIDTH>POS_WIDTH)?TIME_WIDTH:POS_WIDTH)-1:0] csr_data
);

   localparam int T  = TIME_WIDTH;
   localparam int P  = POS_WIDTH;
   localparam int FB = cptraj_pkg::FRAC_BITS;
   localparam int QW = cptraj_pkg::Q_WIDTH;
   localparam int RSP_W = ((POS_WIDTH + 7) / 8) * 8;

   // Pipeline stage numbers.
   localparam int DIV_STAGES = QW;               // stages 1..25: one quotient bit each
   localparam int ST_SQ   = DIV_STAGES + 1;      // s*s, |goal - init|
   localparam int ST_S2K  = DIV_STAGES + 2;      // round s^2, form 3 - 2s
   localparam int ST_PROD = DIV_STAGES + 3;      // s^2 * (3 - 2s)
   localparam int ST_H    = DIV_STAGES + 4;      // round and clamp h
   localparam int ST_PP   = DIV_STAGES + 5;      // split magnitude times h
   localparam int ST_M    = DIV_STAGES + 6;      // recombine to m
   localparam int NST     = ST_M + 1;

   // Magnitude split for the final scaling: high part above the fraction bits.
   localparam int HI_W = (P > FB) ? (P - FB) : 1;
   localparam int MX_W = FB + HI_W;
   localparam int MW   = HI_W + QW + 1;

   localparam logic [cptraj_pkg::SQ_WIDTH-1:0]   HALF_SQ   = cptraj_pkg::SQ_WIDTH'(1) << (FB - 1);
   localparam logic [cptraj_pkg::PROD_WIDTH-1:0] HALF_PROD = cptraj_pkg::PROD_WIDTH'(1) << (FB - 1);
   localparam logic [2*FB:0]                     HALF_LO   = (2*FB+1)'(1) << (FB - 1);
   localparam logic [cptraj_pkg::K_WIDTH-1:0]    THREE_Q   = cptraj_pkg::K_WIDTH'(3) << FB;
   localparam logic [cptraj_pkg::HR_WIDTH-1:0]   ONE_HR    = cptraj_pkg::HR_WIDTH'(1) << FB;
   localparam logic [QW-1:0]                     ONE_Q     = QW'(1) << FB;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [P-1:0] init_pos_ff;
   logic [P-1:0] goal_pos_ff;
   logic [T-1:0] duration_ff;
   logic [T-1:0] start_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_pos_ff <= '0;
         goal_pos_ff <= '0;
         duration_ff <= T'(1);
         start_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            cptraj_pkg::CSR_INITIAL_POSITION: init_pos_ff <= csr_data[P-1:0];
            cptraj_pkg::CSR_GOAL_POSITION:    goal_pos_ff <= csr_data[P-1:0];
            cptraj_pkg::CSR_MOVE_DURATION:    duration_ff <= csr_data[T-1:0];
            cptraj_pkg::CSR_START_TIME:       start_ff    <= csr_data[T-1:0];
            default: ;
         endcase
      end
   end

   // Effective duration: zero counts as one tick.
   logic [T:0] dur_ext;
   assign dur_ext = (duration_ff == '0) ? (T+1)'(1) : {1'b0, duration_ff};

   // ------------------------------------------------------------------
   // Pipeline control: every stage moves together unless the skid is full
   // ------------------------------------------------------------------
   logic en;
   logic skid_v_ff;
   logic valid_ff  [0:NST-1];
   logic before_ff [0:NST-1];
   logic after_ff  [0:NST-1];

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NST; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: window check and elapsed time
   // ------------------------------------------------------------------
   logic [T-1:0] t_in;
   logic [T:0]   end_in;
   logic         before_in;
   logic         after_in;

   assign t_in      = req_tdata[T-1:0];
   assign end_in    = {1'b0, start_ff} + dur_ext;   // no wrap past the top of time
   assign before_in = t_in < start_ff;
   assign after_in  = {1'b0, t_in} > end_in;

   logic [T:0]    rem_ff [0:DIV_STAGES];
   logic [QW-1:0] q_ff   [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         before_ff[0] <= before_in;
         after_ff[0]  <= after_in;
         for (int k = 1; k < NST; k++) begin
            before_ff[k] <= before_ff[k-1];
            after_ff[k]  <= after_ff[k-1];
         end
         // outside the window the divider just runs on zero
         rem_ff[0]    <= (before_in || after_in) ? '0 : {1'b0, t_in - start_ff};
         q_ff[0]      <= '0;
      end
   end

   // ------------------------------------------------------------------
   // Stages 1..25: restoring divide, s = floor(elapsed * 2^24 / d)
   // First stage takes the integer bit, the rest shift in one fraction bit.
   // ------------------------------------------------------------------
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [T:0] trial;
      logic       ge;

      if (k == 1) begin : g_first
         assign trial = rem_ff[k-1];
      end else begin : g_step
         assign trial = {rem_ff[k-1][T-1:0], 1'b0};
      end

      assign ge = trial >= dur_ext;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? (trial - dur_ext) : trial;
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
         end
      end
   end

   // ------------------------------------------------------------------
   // Polynomial h = 3s^2 - 2s^3 and the move magnitude
   // ------------------------------------------------------------------
   logic [QW-1:0]                     s_ff;
   logic [cptraj_pkg::SQ_WIDTH-1:0]   sq_ff;
   logic [P-1:0]                      mag_sq_ff;
   logic                              neg_sq_ff;
   logic [P:0]                        diff_in;

   assign diff_in = {goal_pos_ff[P-1], goal_pos_ff} - {init_pos_ff[P-1], init_pos_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff      <= q_ff[DIV_STAGES];
         sq_ff     <= q_ff[DIV_STAGES] * q_ff[DIV_STAGES];
         neg_sq_ff <= diff_in[P];
         mag_sq_ff <= diff_in[P] ? P'(~diff_in + (P+1)'(1)) : diff_in[P-1:0];
      end
   end

   logic [cptraj_pkg::SQ_WIDTH-1:0] sq_rnd_in;
   logic [cptraj_pkg::S2_WIDTH-1:0] s2_ff;
   logic [cptraj_pkg::K_WIDTH-1:0]  k_ff;
   logic [P-1:0]                    mag_s2_ff;
   logic                            neg_s2_ff;

   assign sq_rnd_in = sq_ff + HALF_SQ;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff     <= sq_rnd_in[cptraj_pkg::SQ_WIDTH-1:FB];
         k_ff      <= THREE_Q - {1'b0, s_ff, 1'b0};
         mag_s2_ff <= mag_sq_ff;
         neg_s2_ff <= neg_sq_ff;
      end
   end

   logic [cptraj_pkg::PROD_WIDTH-1:0] prod_ff;
   logic [P-1:0]                      mag_pr_ff;
   logic                              neg_pr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= s2_ff * k_ff;
         mag_pr_ff <= mag_s2_ff;
         neg_pr_ff <= neg_s2_ff;
      end
   end

   logic [cptraj_pkg::PROD_WIDTH-1:0] prod_rnd_in;
   logic [cptraj_pkg::HR_WIDTH-1:0]   hr_in;
   logic [QW-1:0]                     h_ff;
   logic [P-1:0]                      mag_h_ff;
   logic                              neg_h_ff;

   assign prod_rnd_in = prod_ff + HALF_PROD;
   assign hr_in       = prod_rnd_in[cptraj_pkg::PROD_WIDTH-1:FB];

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff     <= (hr_in > ONE_HR) ? ONE_Q : hr_in[QW-1:0];   // clamp at exactly one
         mag_h_ff <= mag_pr_ff;
         neg_h_ff <= neg_pr_ff;
      end
   end

   // ------------------------------------------------------------------
   // Scale: m = round(|goal - init| * h), split into high and low halves
   // ------------------------------------------------------------------
   logic [MX_W-1:0]    mag_ext_in;
   logic [HI_W+QW-1:0] phi_ff;
   logic [FB+QW-1:0]   plo_ff;
   logic               neg_pp_ff;

   assign mag_ext_in = MX_W'(mag_h_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff    <= mag_ext_in[MX_W-1:FB] * h_ff;
         plo_ff    <= mag_ext_in[FB-1:0] * h_ff;
         neg_pp_ff <= neg_h_ff;
      end
   end

   logic [2*FB:0] plo_rnd_in;
   logic [MW-1:0] m_in;
   logic [P-1:0]  m_ff;
   logic          neg_m_ff;

   assign plo_rnd_in = (2*FB+1)'(plo_ff) + HALF_LO;
   assign m_in       = MW'(phi_ff) + MW'(plo_rnd_in[2*FB:FB]);

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= m_in[P-1:0];   // never exceeds the magnitude
         neg_m_ff <= neg_pp_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output: pick the window case, then output register with skid behind it
   // ------------------------------------------------------------------
   logic [P-1:0] res_in;
   logic         new_in;
   logic         out_free;
   logic         rsp_v_ff;
   logic [P-1:0] rsp_data_ff;
   logic [P-1:0] skid_data_ff;

   always_comb begin
      if (before_ff[NST-1]) begin
         res_in = init_pos_ff;
      end else if (after_ff[NST-1]) begin
         res_in = goal_pos_ff;
      end else if (neg_m_ff) begin
         res_in = init_pos_ff - m_ff;
      end else begin
         res_in = init_pos_ff + m_ff;
      end
   end

   assign new_in   = en && valid_ff[NST-1];
   assign out_free = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff  <= new_in;
         end
      end else if (new_in) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_v_ff ? skid_data_ff : res_in;
      end
      if (!out_free && new_in) begin
         skid_data_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
